// ===== src/sacl_pkg.sv =====
// Shared constants and types for the set-associative LRU tag store.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int MAX_SETS          = 512;
	localparam int MAX_WAYS          = 8;
	localparam int BLOCK_OFFSET_BITS = 6;

	localparam int ADDR_W    = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int WAY_OUT_W = 3;
	localparam int CNT_W     = 32;
	localparam int STAMP_W   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_INDEX_BITS = 1'b0,
		CFG_WAYS_IN_USE    = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] RST_SET_INDEX_BITS = 4'd4;
	localparam logic [CFG_W-1:0] RST_WAYS_IN_USE    = 4'd1;

	// Status of the queue between the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== src/sacl_front.sv =====
// Front end: configuration registers, item acceptance and address split.
// Depends on sacl_pkg; feeds sacl_queue.
`timescale 1ns / 1ps

module sacl_front #(
	parameter int MAX_SETS          = sacl_pkg::MAX_SETS,
	parameter int MAX_WAYS          = sacl_pkg::MAX_WAYS,
	parameter int BLOCK_OFFSET_BITS = sacl_pkg::BLOCK_OFFSET_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sacl_pkg::ADDR_W-1:0]          byte_address,
	input  logic                                 cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [sacl_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 clearing,
	input  sacl_pkg::qstat_t                     qstat,
	output logic                                 push,
	output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)
		+ (sacl_pkg::ADDR_W - BLOCK_OFFSET_BITS) + MAX_WAYS - 1:0] push_data
);

	localparam int MAX_SB = $clog2(MAX_SETS + 1) - 1;
	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int TAG_W  = sacl_pkg::ADDR_W - BLOCK_OFFSET_BITS;
	localparam int CFG_W  = sacl_pkg::CFG_W;

	logic [CFG_W-1:0]            set_bits_q;
	logic [CFG_W-1:0]            ways_q;
	logic [CFG_W-1:0]            sb;
	logic [CFG_W:0]              nw;
	logic [sacl_pkg::ADDR_W-1:0] line;
	logic [sacl_pkg::ADDR_W-1:0] set_full;
	logic [sacl_pkg::ADDR_W-1:0] tag_full;
	logic [MAX_WAYS-1:0]         way_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= sacl_pkg::RST_SET_INDEX_BITS;
			ways_q     <= sacl_pkg::RST_WAYS_IN_USE;
		end else if (cfg_we) begin
			unique case (sacl_pkg::cfg_reg_t'(cfg_addr))
				sacl_pkg::CFG_SET_INDEX_BITS: set_bits_q <= cfg_data;
				sacl_pkg::CFG_WAYS_IN_USE:    ways_q     <= cfg_data;
			endcase
		end
	end

	// Set bits saturate so that the set index always lands inside the store.
	always_comb begin
		if (int'(set_bits_q) > MAX_SB)
			sb = CFG_W'(MAX_SB);
		else
			sb = set_bits_q;
		if (ways_q == '0)
			nw = (CFG_W+1)'(1);
		else if (int'(ways_q) > MAX_WAYS)
			nw = (CFG_W+1)'(MAX_WAYS);
		else
			nw = {1'b0, ways_q};
		for (int w = 0; w < MAX_WAYS; w++)
			way_mask[w] = (w < int'(nw));
	end

	assign line     = byte_address >> BLOCK_OFFSET_BITS;
	assign set_full = line & ((32'd1 << sb) - 32'd1);
	assign tag_full = line >> sb;

	assign busy      = clearing | qstat.full;
	assign push      = start & ~busy;
	assign push_data = {set_full[SET_W-1:0], tag_full[TAG_W-1:0], way_mask};

endmodule

// ===== src/sacl_queue.sv =====
// Two-entry queue that decouples the front end from the lookup back end.
// Depends on sacl_pkg for its status type.
`timescale 1ns / 1ps

module sacl_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output sacl_pkg::qstat_t qstat
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	assign pop_data    = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);

endmodule

// ===== src/sacl_back.sv =====
// Back end: set memory, tag compare, LRU choice, line update and counters.
// Depends on sacl_pkg; takes items from sacl_queue.
`timescale 1ns / 1ps

module sacl_back #(
	parameter int MAX_SETS          = sacl_pkg::MAX_SETS,
	parameter int MAX_WAYS          = sacl_pkg::MAX_WAYS,
	parameter int BLOCK_OFFSET_BITS = sacl_pkg::BLOCK_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sacl_pkg::qstat_t                  qstat,
	output logic                              pop,
	input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)
		+ (sacl_pkg::ADDR_W - BLOCK_OFFSET_BITS) + MAX_WAYS - 1:0] pop_data,
	output logic                              clearing,
	output logic                              done,
	output logic                              hit,
	output logic [sacl_pkg::WAY_OUT_W-1:0]    way_used,
	output logic                              evicted,
	output logic [sacl_pkg::CNT_W-1:0]        access_count,
	output logic [sacl_pkg::CNT_W-1:0]        miss_count
);

	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int TAG_W   = sacl_pkg::ADDR_W - BLOCK_OFFSET_BITS;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LEAVES  = 1 << WAY_W;
	localparam int STAMP_W = sacl_pkg::STAMP_W;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} way_t;

	typedef way_t [MAX_WAYS-1:0] row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

	state_t state_q;

	row_t             mem [MAX_SETS];
	row_t             row_q;
	logic             mem_re;
	logic             mem_we;
	logic [SET_W-1:0] mem_waddr;
	row_t             mem_wdata;
	row_t             upd_row;

	logic             clearing_q;
	logic [SET_W-1:0] clr_idx_q;

	logic [SET_W-1:0]    q_set;
	logic [TAG_W-1:0]    q_tag;
	logic [MAX_WAYS-1:0] q_mask;

	logic [SET_W-1:0]    set_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic [MAX_WAYS-1:0] mask_s1;
	logic                hit_s2;
	logic                evict_s2;
	logic [WAY_W-1:0]    way_s2;

	logic               any_hit;
	logic               any_inv;
	logic [WAY_W-1:0]   hit_way;
	logic [WAY_W-1:0]   inv_way;
	logic [STAMP_W-1:0] nd_stamp [2*LEAVES];
	logic [WAY_W-1:0]   nd_way   [2*LEAVES];
	logic               nd_ok    [2*LEAVES];

	assign {q_set, q_tag, q_mask} = pop_data;

	assign mem_re    = (state_q == ST_IDLE) && !qstat.empty && !clearing_q;
	assign pop       = mem_re;
	assign clearing  = clearing_q;
	assign mem_we    = clearing_q || (state_q == ST_UPD);
	assign mem_waddr = clearing_q ? clr_idx_q : set_s1;
	assign mem_wdata = clearing_q ? row_t'('0) : upd_row;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			row_q <= mem[q_set];
	end

	// Hits and invalid ways are searched over all ways; the lowest-numbered one wins.
	always_comb begin
		any_hit = 1'b0;
		any_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (mask_s1[w] && row_q[w].valid && row_q[w].tag == tag_s1) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (mask_s1[w] && !row_q[w].valid) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
	end

	// Tree of stamp compares; on equal stamps the higher-numbered way wins.
	always_comb begin
		for (int n = 0; n < 2 * LEAVES; n++) begin
			nd_stamp[n] = '0;
			nd_way[n]   = '0;
			nd_ok[n]    = 1'b0;
		end
		for (int i = 0; i < LEAVES; i++) begin
			nd_way[LEAVES + i] = WAY_W'(i);
			if (i < MAX_WAYS) begin
				nd_stamp[LEAVES + i] = row_q[i].stamp;
				nd_ok[LEAVES + i]    = mask_s1[i];
			end
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (nd_ok[2*n+1] && (!nd_ok[2*n] || nd_stamp[2*n+1] <= nd_stamp[2*n])) begin
				nd_stamp[n] = nd_stamp[2*n+1];
				nd_way[n]   = nd_way[2*n+1];
				nd_ok[n]    = 1'b1;
			end else begin
				nd_stamp[n] = nd_stamp[2*n];
				nd_way[n]   = nd_way[2*n];
				nd_ok[n]    = nd_ok[2*n];
			end
		end
	end

	// Hit and fill alike leave the chosen way valid, tagged and stamped.
	always_comb begin
		upd_row              = row_q;
		upd_row[way_s2].valid = 1'b1;
		upd_row[way_s2].tag   = tag_s1;
		upd_row[way_s2].stamp = access_count;
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			set_s1  <= q_set;
			tag_s1  <= q_tag;
			mask_s1 <= q_mask;
		end
		if (state_q == ST_LOOK) begin
			hit_s2 <= any_hit;
			priority if (any_hit) begin
				way_s2   <= hit_way;
				evict_s2 <= 1'b0;
			end else if (any_inv) begin
				way_s2   <= inv_way;
				evict_s2 <= 1'b0;
			end else begin
				way_s2   <= nd_way[1];
				evict_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clearing_q   <= 1'b1;
			clr_idx_q    <= '0;
			done         <= 1'b0;
			hit          <= 1'b0;
			way_used     <= '0;
			evicted      <= 1'b0;
			access_count <= '0;
			miss_count   <= '0;
		end else begin
			done <= 1'b0;
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + SET_W'(1);
				if (clr_idx_q == SET_W'(MAX_SETS - 1))
					clearing_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (mem_re)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q      <= ST_IDLE;
					done         <= 1'b1;
					hit          <= hit_s2;
					way_used     <= sacl_pkg::WAY_OUT_W'(way_s2);
					evicted      <= evict_s2;
					access_count <= access_count + sacl_pkg::CNT_W'(1);
					miss_count   <= miss_count + sacl_pkg::CNT_W'(!hit_s2);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative LRU tag store.
// Depends on sacl_pkg, sacl_front, sacl_queue and sacl_back.
//
// Use: an item is one byte address on byte_address, taken at a rising edge
// with start high and busy low. Each item gives one result, shown for exactly
// one cycle with done high: hit, way_used, evicted and the running
// access_count and miss_count. The receiver cannot hold results off; they
// are taken at the edge that ends the done cycle.
// Configuration is written through cfg_we, cfg_addr and cfg_data, one
// register per edge, with no wait; write it only while the block is idle.
// Flow: an accepted item enters the queue; the back end pops it with the
// read of its set row (ST_IDLE), compares tags and stamps (ST_LOOK), then
// writes the row back and registers the result (ST_UPD). It takes no new
// item before that write-back is done. A two-entry queue takes further items
// meanwhile; busy is high while it is full.
// Reset: counters and registers take their reset values; a clearing pass
// then writes every set row with its valid bits clear, with busy high.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup #(
	parameter int MAX_SETS          = sacl_pkg::MAX_SETS,
	parameter int MAX_WAYS          = sacl_pkg::MAX_WAYS,
	parameter int BLOCK_OFFSET_BITS = sacl_pkg::BLOCK_OFFSET_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [sacl_pkg::ADDR_W-1:0]       byte_address,
	input  logic                              cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [sacl_pkg::CFG_W-1:0]        cfg_data,
	output logic                              done,
	output logic                              hit,
	output logic [sacl_pkg::WAY_OUT_W-1:0]    way_used,
	output logic                              evicted,
	output logic [sacl_pkg::CNT_W-1:0]        access_count,
	output logic [sacl_pkg::CNT_W-1:0]        miss_count
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int TAG_W = sacl_pkg::ADDR_W - BLOCK_OFFSET_BITS;
	localparam int ENT_W = SET_W + TAG_W + MAX_WAYS;

	logic             push;
	logic [ENT_W-1:0] push_data;
	logic             pop;
	logic [ENT_W-1:0] pop_data;
	logic             clearing;
	sacl_pkg::qstat_t qstat;

	sacl_front #(
		.MAX_SETS          (MAX_SETS),
		.MAX_WAYS          (MAX_WAYS),
		.BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.byte_address (byte_address),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.clearing     (clearing),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	sacl_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	sacl_back #(
		.MAX_SETS          (MAX_SETS),
		.MAX_WAYS          (MAX_WAYS),
		.BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop          (pop),
		.pop_data     (pop_data),
		.clearing     (clearing),
		.done         (done),
		.hit          (hit),
		.way_used     (way_used),
		.evicted      (evicted),
		.access_count (access_count),
		.miss_count   (miss_count)
	);

endmodule

// ===== src/sacl_checker.sv =====
// Port-level checks on result sequencing and counters of the tag store.
// Depends on sacl_pkg; bound to set_assoc_cache_lru_lookup below.
`timescale 1ns / 1ps

module sacl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       done,
	input logic                       hit,
	input logic                       evicted,
	input logic [sacl_pkg::CNT_W-1:0] access_count,
	input logic [sacl_pkg::CNT_W-1:0] miss_count
);

	// The back end needs a full read, compare and write per item.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high in two consecutive cycles");

	a_access_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> access_count == $past(access_count) + sacl_pkg::CNT_W'(1))
		else $error("access_count did not advance by one with a result");

	a_access_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(access_count) && $stable(miss_count))
		else $error("counters changed without a result");

	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit && miss_count == $past(miss_count))
			|| (!hit && miss_count == $past(miss_count) + sacl_pkg::CNT_W'(1)))
		else $error("miss_count does not follow the hit flag");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted)
		else $error("eviction reported on a hit");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (.*);
